/* hdl/dbig_pkg.sv */
// shared types, constants and the slot lookup table of the block id generator
package dbig_pkg;

   // sizing of the class table and of each window
   localparam int NUM_CLASSES = 4;
   localparam int WINDOW_SIZE = 16;

   // field widths
   localparam int ROLL_W  = 7;
   localparam int LIMIT_W = 7;
   localparam int COPY_W  = 16;
   localparam int ID_W    = 64;
   localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int FILL_W  = $clog2(WINDOW_SIZE + 1);
   localparam int ADDR_W  = CLS_W + SLOT_W;
   localparam int WIN_DEPTH = 2 ** ADDR_W;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CUM_LIMIT_BASE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COPIES_BASE    = 3'd4;

   // beats
   typedef struct packed {
      logic [ROLL_W-1:0] class_roll;
      logic [ROLL_W-1:0] slot_pick;
   } req_beat_type;

   typedef struct packed {
      logic [ID_W-1:0] gen_id;
      logic            is_repeat;
   } rsp_beat_type;

   // one window entry as held in memory
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [COPY_W-1:0] left;
   } win_entry_type;

   typedef logic [NUM_CLASSES-1:0][LIMIT_W-1:0] limit_array_type;
   typedef logic [NUM_CLASSES-1:0][COPY_W-1:0]  copies_array_type;
   typedef logic [NUM_CLASSES-1:0][FILL_W-1:0]  fill_array_type;

   // outcome of class selection
   typedef struct packed {
      logic              unique_blk;
      logic [CLS_W-1:0]  owner;
      logic [COPY_W-1:0] want;
   } sel_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_RD_LAST  = 5'b00100,
      S_WRBACK   = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

   // pick to slot index, worked out at elaboration
   typedef logic [2**ROLL_W-1:0][SLOT_W-1:0] slot_table_type;

   function automatic slot_table_type build_slot_table();
      slot_table_type t;
      for (int i = 0; i < 2**ROLL_W; i++) begin
         t[i] = SLOT_W'(i % WINDOW_SIZE);
      end
      return t;
   endfunction

   localparam slot_table_type SLOT_TABLE = build_slot_table();

endpackage

/* hdl/dbig_ram.sv */
// generic simple dual port ram with registered read
module dbig_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dbig_sel.sv */
// copy class selection and window owner lookup
module dbig_sel (
   input  logic [dbig_pkg::ROLL_W-1:0]    class_roll,
   input  dbig_pkg::limit_array_type      cum_limit,
   input  dbig_pkg::copies_array_type     copies,
   output dbig_pkg::sel_type              sel
);
   import dbig_pkg::*;

   logic              found;
   logic [CLS_W-1:0]  cls;
   logic [COPY_W-1:0] want;
   logic              owner_found;
   logic [CLS_W-1:0]  owner;

   // first class whose bound lies above the draw
   always_comb begin
      found = 1'b0;
      cls   = '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (!found && (class_roll < cum_limit[i])) begin
            found = 1'b1;
            cls   = CLS_W'(i);
         end
      end
      want = copies[cls];
   end

   // window owner: first class up to the chosen one with the same copy count
   always_comb begin
      owner_found = 1'b0;
      owner       = cls;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (!owner_found && (CLS_W'(i) <= cls) && (copies[i] == want)) begin
            owner_found = 1'b1;
            owner       = CLS_W'(i);
         end
      end
   end

   assign sel.unique_blk = !found || (want == '0);
   assign sel.owner      = owner;
   assign sel.want       = want;

endmodule

/* hdl/dedup_block_id_generator_top.sv */
// top level of the block id generator: config registers, sequencer, window memory
//
// channel   direction  handshake            beat
// req       in         req_valid/req_stall  class_roll, slot_pick
// rsp       out        rsp_valid/rsp_stall  gen_id, is_repeat
// csr       in         csr_wr_en            csr_index, csr_wdata
//
// a unique block or a window append passes from accept through the dispatch and done states
// a reuse from a full window adds two reads of the window memory
// (chosen and last entry) through its single read port, then one write-back
// req_stall is high from accept until the result is loaded into the output register
// a pending result only holds back the final load, not the window work
// synchronous reset clears config to defaults, next id and all window fills
module dedup_block_id_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dbig_pkg::req_beat_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dbig_pkg::rsp_beat_type          rsp_data,
   input  logic                            csr_wr_en,
   input  logic [dbig_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbig_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dbig_pkg::*;

   state_type        state_ff, state_in;
   limit_array_type  cum_limit_ff, cum_limit_in;
   copies_array_type copies_ff, copies_in;
   logic [ID_W-1:0]  next_id_ff, next_id_in;
   fill_array_type   fill_ff, fill_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CLS_W-1:0]  owner_ff, owner_in;
   logic [COPY_W-1:0] want_ff, want_in;
   logic              unique_ff, unique_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   win_entry_type     slot_entry_ff, slot_entry_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic              res_rep_ff, res_rep_in;
   rsp_beat_type      rsp_data_ff, rsp_data_in;

   sel_type           sel;
   logic [FILL_W-1:0] owner_fill;
   logic              win_full;
   logic [SLOT_W-1:0] last_slot;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   win_entry_type     ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   win_entry_type     ram_rd_data;

   // class choice from the incoming draw
   dbig_sel u_sel (
      .class_roll (req_data.class_roll),
      .cum_limit  (cum_limit_ff),
      .copies     (copies_ff),
      .sel        (sel)
   );

   // window ids and remaining copies of all classes
   dbig_ram #(
      .WIDTH ($bits(win_entry_type)),
      .DEPTH (WIN_DEPTH)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // configuration writes
   always_comb begin
      cum_limit_in = cum_limit_ff;
      copies_in    = copies_ff;
      if (csr_wr_en) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            if (csr_index == CSR_IDX_W'(CSR_CUM_LIMIT_BASE + CSR_IDX_W'(i))) begin
               cum_limit_in[i] = csr_wdata[LIMIT_W-1:0];
            end
            if (csr_index == CSR_IDX_W'(CSR_COPIES_BASE + CSR_IDX_W'(i))) begin
               copies_in[i] = csr_wdata[COPY_W-1:0];
            end
         end
      end
   end

   // owner window status
   assign owner_fill = fill_ff[owner_ff];
   assign win_full   = owner_fill >= FILL_W'(WINDOW_SIZE);
   assign last_slot  = SLOT_W'(owner_fill - FILL_W'(1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      next_id_in    = next_id_ff;
      fill_in       = fill_ff;
      owner_in      = owner_ff;
      want_in       = want_ff;
      unique_in     = unique_ff;
      slot_in       = slot_ff;
      slot_entry_in = slot_entry_ff;
      res_id_in     = res_id_ff;
      res_rep_in    = res_rep_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {owner_ff, slot_ff};
      ram_wr_data   = slot_entry_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = {owner_ff, slot_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               owner_in  = sel.owner;
               want_in   = sel.want;
               unique_in = sel.unique_blk;
               slot_in   = SLOT_TABLE[req_data.slot_pick];
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (unique_ff) begin
               res_id_in  = next_id_ff;
               res_rep_in = 1'b0;
               next_id_in = next_id_ff + ID_W'(1);
               state_in   = S_DONE;
            end else if (win_full) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = {owner_ff, slot_ff};
               state_in    = S_RD_LAST;
            end else begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = {owner_ff, owner_fill[SLOT_W-1:0]};
               ram_wr_data.id    = next_id_ff;
               ram_wr_data.left  = want_ff;
               fill_in[owner_ff] = owner_fill + FILL_W'(1);
               res_id_in         = next_id_ff;
               res_rep_in        = 1'b0;
               next_id_in        = next_id_ff + ID_W'(1);
               state_in          = S_DONE;
            end
         end
         S_RD_LAST: begin
            slot_entry_in.id   = ram_rd_data.id;
            slot_entry_in.left = ram_rd_data.left - COPY_W'(1);
            ram_rd_en          = 1'b1;
            ram_rd_addr        = {owner_ff, last_slot};
            state_in           = S_WRBACK;
         end
         S_WRBACK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {owner_ff, slot_ff};
            if (slot_entry_ff.left == '0) begin
               // swap-remove: last entry moves into the emptied slot
               ram_wr_data       = ram_rd_data;
               fill_in[owner_ff] = owner_fill - FILL_W'(1);
            end else begin
               ram_wr_data = slot_entry_ff;
            end
            res_id_in  = slot_entry_ff.id;
            res_rep_in = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.gen_id    = res_id_ff;
               rsp_data_in.is_repeat = res_rep_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         next_id_ff   <= '0;
         fill_ff      <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cum_limit_ff[i] <= LIMIT_W'(100);
            copies_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next_id_ff   <= next_id_in;
         fill_ff      <= fill_in;
         cum_limit_ff <= cum_limit_in;
         copies_ff    <= copies_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      owner_ff      <= owner_in;
      want_ff       <= want_in;
      unique_ff     <= unique_in;
      slot_ff       <= slot_in;
      slot_entry_ff <= slot_entry_in;
      res_id_ff     <= res_id_in;
      res_rep_ff    <= res_rep_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next id only advances out of dispatch
   a_next_id_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(next_id_ff) |-> ($past(state_ff) == S_DISPATCH))
      else $error("next id moved outside dispatch");

   // window fills only move on append or write-back
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(fill_ff) |->
         ($past(state_ff) == S_DISPATCH || $past(state_ff) == S_WRBACK))
      else $error("window fill moved outside append or write-back");

   // memory is only written in dispatch or write-back
   a_ram_wr_state: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_DISPATCH || state_ff == S_WRBACK))
      else $error("window write in wrong state");

   // a new result beat only appears after the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result beat raised outside done");

   // a repeated id only follows a window read
   a_repeat_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_rep_ff) |-> ($past(state_ff) == S_WRBACK
         || $past(state_ff) == S_DONE))
      else $error("repeat result without window read");

endmodule

/* bench/tb_top.sv */
// self-checking testbench of the block id generator: directed and random request streams
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dbig_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 12;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 18;
   localparam int PHASE_ITEMS    = 100;

   // block ports; the inputs driven here are known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_beat_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_beat_type          rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // idling chances in percent: per request for input gaps, per cycle for result stalls
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;

   // predictor state: class table, fresh id counter and per class windows
   logic [LIMIT_W-1:0] class_limit  [NUM_CLASSES];
   logic [COPY_W-1:0]  class_copies [NUM_CLASSES];
   logic [ID_W-1:0]    fresh_id;
   logic [ID_W-1:0]    slot_id      [NUM_CLASSES][WINDOW_SIZE];
   logic [COPY_W-1:0]  slot_left    [NUM_CLASSES][WINDOW_SIZE];
   int unsigned        slot_fill    [NUM_CLASSES];

   // results still owed by the block, oldest first
   rsp_beat_type pending_ids [$];
   int unsigned  mismatch_count = 0;
   int unsigned  idle_cycles;

   dedup_block_id_generator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor back to its reset state
   function automatic void clear_prediction();
      for (int i = 0; i < NUM_CLASSES; i++) begin
         class_limit[i]  = LIMIT_W'(100);
         class_copies[i] = '0;
         slot_fill[i]    = 0;
      end
      fresh_id = '0;
   endfunction

   // expected result for one request, advancing the predicted state
   function automatic rsp_beat_type predict_result(req_beat_type beat);
      rsp_beat_type      res;
      int                cls;
      int                owner;
      int unsigned       slot;
      int unsigned       last;
      logic [COPY_W-1:0] want;
      logic [COPY_W-1:0] left;
      cls  = -1;
      want = '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         if (cls < 0 && beat.class_roll < class_limit[i]) begin
            cls  = i;
            want = class_copies[i];
         end
      end
      // unique block, or no class took the draw
      if (cls < 0 || want == '0) begin
         res.gen_id    = fresh_id;
         res.is_repeat = 1'b0;
         fresh_id      = fresh_id + 1'b1;
         return res;
      end
      // the window belongs to the first class with the same copy count
      owner = cls;
      for (int i = cls - 1; i >= 0; i--) begin
         if (class_copies[i] == want) owner = i;
      end
      if (slot_fill[owner] >= WINDOW_SIZE) begin
         // full window: reuse one entry, swap-remove it once used up
         slot          = beat.slot_pick % WINDOW_SIZE;
         last          = slot_fill[owner] - 1;
         res.gen_id    = slot_id[owner][slot];
         res.is_repeat = 1'b1;
         left          = slot_left[owner][slot] - 1'b1;
         slot_left[owner][slot] = left;
         if (left == '0) begin
            slot_id[owner][slot]   = slot_id[owner][last];
            slot_left[owner][slot] = slot_left[owner][last];
            slot_fill[owner]       = last;
         end
      end else begin
         // room left: append a fresh id with the full copy count
         slot_id[owner][slot_fill[owner]]   = fresh_id;
         slot_left[owner][slot_fill[owner]] = want;
         slot_fill[owner]++;
         res.gen_id    = fresh_id;
         res.is_repeat = 1'b0;
         fresh_id      = fresh_id + 1'b1;
      end
      return res;
   endfunction

   // one register write, mirrored into the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx < CSR_COPIES_BASE) begin
         class_limit[idx - CSR_CUM_LIMIT_BASE] = data[LIMIT_W-1:0];
      end else begin
         class_copies[idx - CSR_COPIES_BASE] = data;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // whole class table; unused upper bits of the bounds carry junk
   task automatic program_classes(input limit_array_type lim, input copies_array_type cop);
      logic [CSR_DATA_W-1:0] junk;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         junk = CSR_DATA_W'($urandom_range(0, 511)) << LIMIT_W;
         write_reg(CSR_IDX_W'(CSR_CUM_LIMIT_BASE + i), junk | CSR_DATA_W'(lim[i]));
      end
      for (int i = 0; i < NUM_CLASSES; i++) begin
         write_reg(CSR_IDX_W'(CSR_COPIES_BASE + i), cop[i]);
      end
   endtask

   // send one request beat; the expectation is queued at the accepting edge
   task automatic send_request(input logic [ROLL_W-1:0] roll, input logic [ROLL_W-1:0] pick);
      req_beat_type beat;
      rsp_beat_type owed;
      int unsigned  gap;
      beat.class_roll = roll;
      beat.slot_pick  = pick;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? $urandom_range(1, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      owed        = predict_result(beat);
      pending_ids = {pending_ids, owed};
      @(negedge clock);
   endtask

   // hold off new requests until every owed result has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_ids.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_request();
      logic [ROLL_W-1:0] roll;
      roll = ($urandom_range(0, 99) < 85) ? ROLL_W'($urandom_range(0, 99))
                                           : ROLL_W'($urandom_range(100, 127));
      send_request(roll, ROLL_W'($urandom_range(0, 127)));
   endtask

   task automatic program_random_classes();
      limit_array_type  lim;
      copies_array_type cop;
      int unsigned      acc;
      acc = 0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
         // mostly rising bounds, sometimes any value the field holds
         if ($urandom_range(0, 5) == 0) begin
            lim[i] = LIMIT_W'($urandom_range(0, 127));
         end else begin
            acc = acc + $urandom_range(0, 45);
            if (acc > 100 || i == NUM_CLASSES - 1) acc = 100;
            lim[i] = LIMIT_W'(acc);
         end
         // mostly small counts so windows fill, drain and get shared
         case ($urandom_range(0, 9)) inside
            [0:2]:   cop[i] = '0;
            8:       cop[i] = '1;
            9:       cop[i] = COPY_W'($urandom);
            default: cop[i] = COPY_W'($urandom_range(1, 3));
         endcase
      end
      program_classes(lim, cop);
   endtask

   // reset defaults: every draw gives a fresh id, no class takes 127
   task automatic test_fresh_ids();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      send_request(ROLL_W'(0), ROLL_W'(0));
      send_request(ROLL_W'(99), ROLL_W'(127));
      send_request(ROLL_W'(127), ROLL_W'(85));
   endtask

   // two classes share one window; fill it, reuse last and first slots
   task automatic test_shared_window();
      limit_array_type  lim;
      copies_array_type cop;
      lim[0] = LIMIT_W'(0);
      lim[1] = LIMIT_W'(50);
      lim[2] = LIMIT_W'(100);
      lim[3] = LIMIT_W'(127);
      cop[0] = COPY_W'(7);
      cop[1] = COPY_W'(1);
      cop[2] = COPY_W'(1);
      cop[3] = '1;
      wait_for_results();
      program_classes(lim, cop);
      rsp_stall_pct = 30;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         send_request((i % 2 == 0) ? ROLL_W'(0) : ROLL_W'(99), ROLL_W'($urandom_range(0, 127)));
      end
      // last slot used up: removal swaps the entry with itself
      send_request(ROLL_W'(49), ROLL_W'(127));
      send_request(ROLL_W'(0), ROLL_W'(3));
      // first slot used up: the last entry moves into it
      send_request(ROLL_W'(60), ROLL_W'(0));
      send_request(ROLL_W'(0), ROLL_W'(0));
      send_request(ROLL_W'(10), ROLL_W'(16));
      // bound above 100, then a draw that no class takes
      send_request(ROLL_W'(100), ROLL_W'(64));
      send_request(ROLL_W'(127), ROLL_W'(127));
   endtask

   // copy count changed under a partly used window
   task automatic test_copy_change();
      wait_for_results();
      write_reg(CSR_IDX_W'(CSR_COPIES_BASE + 1), COPY_W'(2));
      send_request(ROLL_W'(0), ROLL_W'(5));
      send_request(ROLL_W'(99), ROLL_W'(5));
   endtask

   // random class tables, pausing for all results before each retune
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         program_random_classes();
         req_gap_pct   = (phase % 3 == 0) ? 0 : 25;
         rsp_stall_pct = (phase % 3 == 1) ? 0 : 25;
         repeat (PHASE_ITEMS) send_random_request();
      end
   endtask

   // last stretch at full rate, no idling on either side
   task automatic test_quiet_tail();
      wait_for_results();
      program_random_classes();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      repeat (PHASE_ITEMS) send_random_request();
   endtask

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // result side back-pressure in random bursts
   always begin
      @(negedge clock);
      if (reset || $urandom_range(0, 99) >= rsp_stall_pct) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_beat_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_ids.size() == 0) begin
            log_mismatch($sformatf("unexpected result: gen_id %h is_repeat %b",
                                   rsp_data.gen_id, rsp_data.is_repeat));
         end else begin
            owed = pending_ids.pop_front();
            if (rsp_data.gen_id !== owed.gen_id ||
                rsp_data.is_repeat !== owed.is_repeat) begin
               log_mismatch($sformatf("gen_id exp %h got %h, is_repeat exp %b got %b",
                                      owed.gen_id, rsp_data.gen_id,
                                      owed.is_repeat, rsp_data.is_repeat));
            end
         end
      end
   end

   // stop a hung run: too many cycles without any beat or write
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("status: fail");
      $finish;
   end

   // test sequence
   initial begin
      clear_prediction();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_fresh_ids();
      test_shared_window();
      test_copy_change();
      test_random_traffic();
      test_quiet_tail();
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_ids.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
